### src/csdi_pkg.sv
`timescale 1ns / 1ps
package csdi_pkg;

  localparam int DATA_W         = 32;
  localparam int COEF_W         = 17;
  localparam int MAX_AXES       = 3;
  localparam int MODE_W         = 3;
  localparam int REG_IDX_W      = 3;
  localparam int CSDI_FRAC_BITS = 16;
  localparam int CSDI_AXES      = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_STIFFNESS_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STIFFNESS_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STIFFNESS_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DT_OVER_M   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TIME_STEP   = 3'd7;

  // damping resets to exactly one in Q1.16
  localparam logic [COEF_W-1:0] DAMPING_RESET = 17'h1_0000;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  // add/sub: a op b; mul: coef (unsigned) * b, scaled back by the fraction bits
  typedef struct packed {
    alu_op_e           op;
    logic [DATA_W-1:0] coef;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [MAX_AXES-1:0][DATA_W-1:0] stiffness;
    logic [MAX_AXES-1:0][COEF_W-1:0] damping;
    logic [DATA_W-1:0]               dt_over_mass;
    logic [COEF_W-1:0]               time_step;
  } cfg_t;

endpackage

### src/cartesian_spring_damper_integrator.sv
`timescale 1ns / 1ps
// Three-axis spring-damper integrator, signed Q16.16 state, saturating arithmetic.
// Each word on the slave side carries a mode in tuser (clear, add force, set target,
// step, restore position, restore velocity) and a vector in tdata; each returns one
// word with the position and velocity that hold afterwards. A step runs eight
// operations per axis (spring difference, spring force, net force, velocity change,
// velocity, damping, position change, position) through one shared multiply/add
// unit, each operation issued and then its result taken back; the block is not
// ready for the next word until the step is through. The result sits in an output
// register, so the next word may be taken while it waits; a result that finishes
// while the previous one still waits holds the block until that one is taken.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
module cartesian_spring_damper_integrator #(
  parameter int FRAC_BITS = csdi_pkg::CSDI_FRAC_BITS,
  parameter int AXES      = csdi_pkg::CSDI_AXES
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // vec_x, vec_y, vec_z
  input  logic [csdi_pkg::MAX_AXES*csdi_pkg::DATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic [csdi_pkg::MODE_W-1:0]                   s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // position_x, position_y, position_z, velocity_x, velocity_y, velocity_z
  output logic [2*csdi_pkg::MAX_AXES*csdi_pkg::DATA_W-1:0] m_axis_tdata,
  input  logic                                          cfg_we_i,
  input  logic [csdi_pkg::REG_IDX_W-1:0]                cfg_addr_i,
  input  logic [csdi_pkg::DATA_W-1:0]                   cfg_wdata_i
);
  import csdi_pkg::*;

  localparam int AXW   = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int OUT_W = 2 * MAX_AXES * DATA_W;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TARGET  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STEP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_POS = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SET_VEL = 3'd5;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [2:0] OP_DIFF   = 3'd0;
  localparam logic [2:0] OP_SPRING = 3'd1;
  localparam logic [2:0] OP_NET    = 3'd2;
  localparam logic [2:0] OP_DV     = 3'd3;
  localparam logic [2:0] OP_VEL    = 3'd4;
  localparam logic [2:0] OP_DAMP   = 3'd5;
  localparam logic [2:0] OP_DP     = 3'd6;
  localparam logic [2:0] OP_POS    = 3'd7;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

  cfg_t     cfg;
  alu_req_t alu_req;
  logic signed [DATA_W-1:0] alu_res;

  logic [1:0]     state_d, state_q;
  logic [2:0]     op_d, op_q;
  logic [AXW-1:0] axis_d, axis_q;
  logic signed [DATA_W-1:0] tmp_d, tmp_q;

  logic signed [DATA_W-1:0] pos_d [AXES];
  logic signed [DATA_W-1:0] pos_q [AXES];
  logic signed [DATA_W-1:0] vel_d [AXES];
  logic signed [DATA_W-1:0] vel_q [AXES];
  logic signed [DATA_W-1:0] frc_d [AXES];
  logic signed [DATA_W-1:0] frc_q [AXES];
  logic signed [DATA_W-1:0] tgt_d [AXES];
  logic signed [DATA_W-1:0] tgt_q [AXES];

  logic             out_valid_d, out_valid_q;
  logic [OUT_W-1:0] out_d, out_q;
  logic [OUT_W-1:0] snap;

  csdi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  csdi_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // operand selection for the current operation of the current axis
  always_comb begin
    alu_req.op   = ALU_ADD;
    alu_req.coef = '0;
    alu_req.a    = '0;
    alu_req.b    = tmp_q;
    case (op_q)
      OP_DIFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = pos_q[axis_q];
        alu_req.b  = tgt_q[axis_q];
      end
      OP_SPRING: begin
        alu_req.op   = ALU_MUL;
        alu_req.coef = cfg.stiffness[axis_q];
      end
      OP_NET: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = frc_q[axis_q];
      end
      OP_DV: begin
        alu_req.op   = ALU_MUL;
        alu_req.coef = cfg.dt_over_mass;
      end
      OP_VEL: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = vel_q[axis_q];
      end
      OP_DAMP: begin
        alu_req.op   = ALU_MUL;
        alu_req.coef = DATA_W'(cfg.damping[axis_q]);
      end
      OP_DP: begin
        alu_req.op   = ALU_MUL;
        alu_req.coef = DATA_W'(cfg.time_step);
      end
      OP_POS: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = pos_q[axis_q];
      end
      default: ;
    endcase
  end

  // result word; axes that are not built read as zero
  for (genvar g = 0; g < MAX_AXES; g++) begin : g_out
    if (g < AXES) begin : g_live
      assign snap[g*DATA_W +: DATA_W]                   = pos_q[g];
      assign snap[(MAX_AXES+g)*DATA_W +: DATA_W]        = vel_q[g];
    end else begin : g_zero
      assign snap[g*DATA_W +: DATA_W]                   = '0;
      assign snap[(MAX_AXES+g)*DATA_W +: DATA_W]        = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    axis_d      = axis_q;
    tmp_d       = tmp_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    frc_d       = frc_q;
    tgt_d       = tgt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_DONE;
          case (s_axis_tuser)
            MODE_CLEAR: begin
              for (int a = 0; a < AXES; a++) begin
                pos_d[a] = '0;
                vel_d[a] = '0;
                frc_d[a] = '0;
                tgt_d[a] = '0;
              end
            end
            MODE_FORCE: begin
              for (int a = 0; a < AXES; a++) begin
                frc_d[a] = sat_add(frc_q[a], $signed(s_axis_tdata[a*DATA_W +: DATA_W]));
              end
            end
            MODE_TARGET: begin
              for (int a = 0; a < AXES; a++) begin
                tgt_d[a] = $signed(s_axis_tdata[a*DATA_W +: DATA_W]);
              end
            end
            MODE_SET_POS: begin
              for (int a = 0; a < AXES; a++) begin
                pos_d[a] = $signed(s_axis_tdata[a*DATA_W +: DATA_W]);
              end
            end
            MODE_SET_VEL: begin
              for (int a = 0; a < AXES; a++) begin
                vel_d[a] = $signed(s_axis_tdata[a*DATA_W +: DATA_W]);
              end
            end
            MODE_STEP: begin
              state_d = S_ISSUE;
              op_d    = OP_DIFF;
              axis_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        tmp_d   = alu_res;
        state_d = S_ISSUE;
        op_d    = op_q + 3'd1;
        if (op_q == OP_DAMP) begin
          vel_d[axis_q] = alu_res;
        end
        if (op_q == OP_POS) begin
          pos_d[axis_q] = alu_res;
          if (axis_q == AXW'(AXES - 1)) begin
            // force and target are consumed by the step
            for (int a = 0; a < AXES; a++) begin
              frc_d[a] = '0;
              tgt_d[a] = '0;
            end
            state_d = S_DONE;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = snap;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_DIFF;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        pos_q[a] <= '0;
        vel_q[a] <= '0;
        frc_q[a] <= '0;
        tgt_q[a] <= '0;
      end
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      frc_q       <= frc_d;
      tgt_q       <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    out_q <= out_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  // last operation of the last axis ends the step with force and target cleared
  a_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && op_q == OP_POS && axis_q == AXW'(AXES - 1))
      |=> (state_q == S_DONE && frc_q[0] == '0 && tgt_q[0] == '0))
    else $error("step did not finish cleanly");

  // a step word starts the sequencer at the first operation of axis zero
  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_STEP)
      |=> (state_q == S_ISSUE && op_q == OP_DIFF && axis_q == '0))
    else $error("step did not start at first operation");

  // a result word only appears after the sequencer has finished
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result word raised outside completion");
`endif

endmodule

### src/csdi_cfg.sv
`timescale 1ns / 1ps
module csdi_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [csdi_pkg::REG_IDX_W-1:0]     cfg_addr_i,
  input  logic [csdi_pkg::DATA_W-1:0]        cfg_wdata_i,
  output csdi_pkg::cfg_t                     cfg_o
);
  import csdi_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_STIFFNESS_X: cfg_d.stiffness[0] = cfg_wdata_i;
        REG_STIFFNESS_Y: cfg_d.stiffness[1] = cfg_wdata_i;
        REG_STIFFNESS_Z: cfg_d.stiffness[2] = cfg_wdata_i;
        REG_DAMPING_X:   cfg_d.damping[0]   = cfg_wdata_i[COEF_W-1:0];
        REG_DAMPING_Y:   cfg_d.damping[1]   = cfg_wdata_i[COEF_W-1:0];
        REG_DAMPING_Z:   cfg_d.damping[2]   = cfg_wdata_i[COEF_W-1:0];
        REG_DT_OVER_M:   cfg_d.dt_over_mass = cfg_wdata_i;
        REG_TIME_STEP:   cfg_d.time_step    = cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiffness    <= '0;
      cfg_q.damping      <= {MAX_AXES{DAMPING_RESET}};
      cfg_q.dt_over_mass <= '0;
      cfg_q.time_step    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/csdi_alu.sv
`timescale 1ns / 1ps
module csdi_alu #(
  parameter int FRAC_BITS = csdi_pkg::CSDI_FRAC_BITS
) (
  input  logic                               clk_i,
  input  csdi_pkg::alu_req_t                 req_i,
  output logic signed [csdi_pkg::DATA_W-1:0] res_o
);
  import csdi_pkg::*;

  localparam int PW   = 2 * DATA_W + 1;
  localparam int HI_W = PW - DATA_W + 1;

  logic signed [PW-1:0]     acc_d, acc_q;
  logic                     mul_d, mul_q;
  logic signed [DATA_W:0]   coef_s;
  logic signed [PW-1:0]     shifted;
  logic [HI_W-1:0]          hi;

  assign coef_s = $signed({1'b0, req_i.coef});

  // stage 1: one product, sum or difference, registered
  always_comb begin
    mul_d = 1'b0;
    case (req_i.op)
      ALU_ADD: acc_d = PW'($signed(req_i.a)) + PW'($signed(req_i.b));
      ALU_SUB: acc_d = PW'($signed(req_i.a)) - PW'($signed(req_i.b));
      ALU_MUL: begin
        acc_d = PW'(coef_s) * PW'($signed(req_i.b));
        mul_d = 1'b1;
      end
      default: acc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mul_q <= mul_d;
  end

  // stage 2: floor scaling of products, then clamp to 32 bits
  assign shifted = mul_q ? (acc_q >>> FRAC_BITS) : acc_q;
  assign hi      = shifted[PW-1:DATA_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      res_o = shifted[DATA_W-1:0];
    end else if (shifted[PW-1]) begin
      res_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

### sim/csdi_tb_pkg.sv
`timescale 1ns / 1ps
package csdi_tb_pkg;

  import csdi_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR       = 3'd0,
    MODE_ADD_FORCE   = 3'd1,
    MODE_SET_TARGET  = 3'd2,
    MODE_STEP        = 3'd3,
    MODE_RESTORE_POS = 3'd4,
    MODE_RESTORE_VEL = 3'd5,
    MODE_SPARE_6     = 3'd6,
    MODE_SPARE_7     = 3'd7
  } mode_e;

  // matches m_axis_tdata: position x at bit 0, velocity z at the top
  typedef struct packed {
    logic [MAX_AXES-1:0][DATA_W-1:0] vel;
    logic [MAX_AXES-1:0][DATA_W-1:0] pos;
  } motion_t;

endpackage

### sim/csdi_state_checker.sv
`timescale 1ns / 1ps
module csdi_state_checker
  import csdi_pkg::*;
  import csdi_tb_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // vec_x, vec_y, vec_z
  input  logic [MAX_AXES*DATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0]              s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // position_x, position_y, position_z, velocity_x, velocity_y, velocity_z
  input  logic [2*MAX_AXES*DATA_W-1:0]   m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [REG_IDX_W-1:0]           cfg_addr_i,
  input  logic [DATA_W-1:0]              cfg_wdata_i,
  output int                             errors_o,
  output int                             pending_o
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic signed [DATA_W-1:0] pos [MAX_AXES];
  logic signed [DATA_W-1:0] vel [MAX_AXES];
  logic signed [DATA_W-1:0] frc [MAX_AXES];
  logic signed [DATA_W-1:0] tgt [MAX_AXES];

  logic [DATA_W-1:0] stiff [MAX_AXES];
  logic [COEF_W-1:0] damp [MAX_AXES];
  logic [DATA_W-1:0] gain;
  logic [COEF_W-1:0] dt;

  motion_t due_states [$];
  motion_t want, got;

  function automatic logic signed [DATA_W-1:0] sat_word(longint x);
    if (x > WORD_MAX) return 32'sh7FFF_FFFF;
    if (x < WORD_MIN) return 32'sh8000_0000;
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] add_sat(logic signed [DATA_W-1:0] a,
                                                       logic signed [DATA_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    return sat_word(s);
  endfunction

  function automatic logic signed [DATA_W-1:0] sub_sat(logic signed [DATA_W-1:0] a,
                                                       logic signed [DATA_W-1:0] b);
    longint s;
    s = longint'(a) - longint'(b);
    return sat_word(s);
  endfunction

  // unsigned coefficient times signed word, floored back to Q16.16
  function automatic logic signed [DATA_W-1:0] scaled(logic [DATA_W-1:0] coef,
                                                      logic signed [DATA_W-1:0] v);
    longint c, w, p;
    c = longint'({32'd0, coef});
    w = v;
    p = c * w;
    return sat_word(p >>> CSDI_FRAC_BITS);
  endfunction

  function automatic void clear_motion();
    for (int a = 0; a < MAX_AXES; a++) begin
      pos[a] = '0;
      vel[a] = '0;
      frc[a] = '0;
      tgt[a] = '0;
    end
  endfunction

  function automatic void advance(mode_e mode, logic [MAX_AXES*DATA_W-1:0] vec);
    logic signed [DATA_W-1:0] diff, acc, v;
    for (int a = 0; a < MAX_AXES; a++) begin
      case (mode)
        MODE_ADD_FORCE:   frc[a] = add_sat(frc[a], vec[a*DATA_W +: DATA_W]);
        MODE_SET_TARGET:  tgt[a] = vec[a*DATA_W +: DATA_W];
        MODE_RESTORE_POS: pos[a] = vec[a*DATA_W +: DATA_W];
        MODE_RESTORE_VEL: vel[a] = vec[a*DATA_W +: DATA_W];
        MODE_STEP: begin
          diff = sub_sat(pos[a], tgt[a]);
          acc  = sub_sat(frc[a], scaled(stiff[a], diff));
          v    = add_sat(vel[a], scaled(gain, acc));
          v    = scaled(DATA_W'(damp[a]), v);
          vel[a] = v;
          pos[a] = add_sat(pos[a], scaled(DATA_W'(dt), v));
          frc[a] = '0;
          tgt[a] = '0;
        end
        default: ;
      endcase
    end
    if (mode == MODE_CLEAR) clear_motion();
  endfunction

  function automatic motion_t snapshot();
    motion_t m;
    for (int a = 0; a < MAX_AXES; a++) begin
      m.pos[a] = pos[a];
      m.vel[a] = vel[a];
    end
    return m;
  endfunction

  function automatic void report(string what, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] act_v);
    errors_o++;
    if (errors_o <= 10)
      $display("%0t: %s mismatch: expected %08h, got %08h", $realtime, what, exp_v, act_v);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_motion();
      for (int a = 0; a < MAX_AXES; a++) begin
        stiff[a] = '0;
        damp[a]  = DAMPING_RESET;
      end
      gain = '0;
      dt   = '0;
      due_states.delete();
      errors_o = 0;
    end else begin
      // a result leaving now belongs to an earlier word, so check before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (due_states.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result word with none expected: %h", $realtime, got);
        end else begin
          want = due_states.pop_front();
          for (int a = 0; a < MAX_AXES; a++) begin
            if (got.pos[a] !== want.pos[a])
              report($sformatf("position[%0d]", a), want.pos[a], got.pos[a]);
            if (got.vel[a] !== want.vel[a])
              report($sformatf("velocity[%0d]", a), want.vel[a], got.vel[a]);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_STIFFNESS_X: stiff[0] = cfg_wdata_i;
          REG_STIFFNESS_Y: stiff[1] = cfg_wdata_i;
          REG_STIFFNESS_Z: stiff[2] = cfg_wdata_i;
          REG_DAMPING_X:   damp[0]  = cfg_wdata_i[COEF_W-1:0];
          REG_DAMPING_Y:   damp[1]  = cfg_wdata_i[COEF_W-1:0];
          REG_DAMPING_Z:   damp[2]  = cfg_wdata_i[COEF_W-1:0];
          REG_DT_OVER_M:   gain     = cfg_wdata_i;
          REG_TIME_STEP:   dt       = cfg_wdata_i[COEF_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance(mode_e'(s_axis_tuser), s_axis_tdata);
        due_states.push_back(snapshot());
      end
    end
    pending_o = due_states.size();
  end

endmodule

### sim/tb_cartesian_spring_damper_integrator.sv
`timescale 1ns / 1ps
module tb_cartesian_spring_damper_integrator;

  import csdi_pkg::*;
  import csdi_tb_pkg::*;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [MAX_AXES*DATA_W-1:0]    s_axis_tdata  = '0;
  logic [MODE_W-1:0]             s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [2*MAX_AXES*DATA_W-1:0]  m_axis_tdata;
  logic                          cfg_we_i      = 1'b0;
  logic [REG_IDX_W-1:0]          cfg_addr_i    = '0;
  logic [DATA_W-1:0]             cfg_wdata_i   = '0;

  int fail_count;
  int pending_words;
  bit idle_on = 1'b1;

  always #5 clk_i = ~clk_i;

  cartesian_spring_damper_integrator dut (.*);

  csdi_state_checker chk (.*, .errors_o(fail_count), .pending_o(pending_words));

  // starts and ends at a falling edge; valid stays high into the next word
  task automatic push_word(mode_e mode, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {vz, vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic wr_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
  endtask

  task automatic program_regs(logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                              logic [31:0] g, logic [31:0] t);
    wr_reg(REG_STIFFNESS_X, kx);
    wr_reg(REG_STIFFNESS_Y, ky);
    wr_reg(REG_STIFFNESS_Z, kz);
    wr_reg(REG_DAMPING_X, dx);
    wr_reg(REG_DAMPING_Y, dy);
    wr_reg(REG_DAMPING_Z, dz);
    wr_reg(REG_DT_OVER_M, g);
    wr_reg(REG_TIME_STEP, t);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic mode_e noise_mode();
    case ($urandom_range(0, 9))
      0, 1:    return MODE_CLEAR;
      2, 3:    return MODE_RESTORE_POS;
      4, 5:    return MODE_RESTORE_VEL;
      6:       return MODE_SPARE_6;
      7:       return MODE_SPARE_7;
      8:       return MODE_ADD_FORCE;
      default: return MODE_STEP;
    endcase
  endfunction

  // mostly force/target/step frames with random content, some noise in between
  task automatic random_words(int n);
    int sent, forces;
    bit with_target;
    sent = 0;
    while (sent < n) begin
      if (sent % 40 < 4) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 85) begin
        forces      = $urandom_range(0, 2);
        with_target = ($urandom_range(0, 1) != 0);
        repeat (forces) push_word(MODE_ADD_FORCE, rand_word(), rand_word(), rand_word());
        if (with_target)
          push_word(MODE_SET_TARGET, rand_word(), rand_word(), rand_word());
        push_word(MODE_STEP, $urandom(), $urandom(), $urandom());
        sent += forces + 1 + int'(with_target);
      end else begin
        push_word(noise_mode(), rand_word(), rand_word(), rand_word());
        sent++;
      end
    end
  endtask

  // receiver: sometimes stalls from the last handshake, sometimes holds a waiting result
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        if ($urandom_range(0, 1)) begin
          do @(posedge clk_i); while (!m_axis_tvalid);
          @(negedge clk_i);
        end
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    program_regs(32'h0000_8000, 32'h0001_0000, 32'h0000_0100,
                 32'h0000_F000, 32'h0001_0000, 32'h0000_8000,
                 32'h0000_4000, 32'h0000_0400);

    // directed: extremes, saturating force sums, spare modes, clear
    push_word(MODE_CLEAR,       32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    push_word(MODE_RESTORE_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    push_word(MODE_RESTORE_VEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    push_word(MODE_SET_TARGET,  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_word(MODE_ADD_FORCE,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_word(MODE_ADD_FORCE,   32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    push_word(MODE_STEP,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_word(MODE_SPARE_6,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(MODE_SPARE_7,     32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    push_word(MODE_ADD_FORCE,   32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000);
    push_word(MODE_STEP,        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_word(MODE_CLEAR,       32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_word(MODE_RESTORE_VEL, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000);
    push_word(MODE_STEP,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_word(MODE_SET_TARGET,  32'h0001_0000, 32'hFFFF_8000, 32'h0010_0000);
    push_word(MODE_STEP,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain();

    program_regs($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                 $urandom_range(0, 32'h0004_0000), $urandom_range(32'hC000, 32'h1_0000),
                 $urandom_range(32'hC000, 32'h1_0000), $urandom_range(32'hC000, 32'h1_0000),
                 $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h1_0000));
    random_words(190);
    drain();

    // all ones: damping and time step mask to just under two
    program_regs('1, '1, '1, '1, '1, '1, '1, '1);
    random_words(190);
    drain();

    program_regs('0, '0, '0, '0, '0, '0, '0, '0);
    random_words(190);
    drain();

    program_regs(32'h0000_2000, 32'h0000_0800, 32'h0001_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 32'h0001_0000);
    random_words(190);
    drain();

    program_regs($urandom(), $urandom(), $urandom(), $urandom_range(0, 32'h1_FFFF),
                 $urandom_range(0, 32'h1_FFFF), $urandom_range(0, 32'h1_FFFF),
                 $urandom(), $urandom_range(0, 32'h1_FFFF));
    random_words(190);
    drain();

    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
